### hdl/feedback_depth_center_parser_macros.svh
// assertion macros for the feedback depth-center parser checker
// no dependencies; included by the checker file
`ifndef FEEDBACK_DEPTH_CENTER_PARSER_MACROS_SVH
`define FEEDBACK_DEPTH_CENTER_PARSER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define FDCP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define FDCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/fdcp_pkg.sv
// constants and decode functions for the feedback depth-center parser
// no dependencies; used by the top level and its checker
package fdcp_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned COUNT_W  = 17;
    localparam int unsigned DIST_W   = 24;
    localparam int unsigned M_DATA_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = 17'd131071;
    localparam logic [DIST_W-1:0]  DIST_MIN   = 24'd7;
    localparam logic [DIST_W-1:0]  DIST_LIMIT = 24'd13107200;

    // token index = token value minus 0x700
    localparam logic [3:0] TOK_PASS_THROUGH = 4'd0;
    localparam logic [3:0] TOK_POINT        = 4'd1;
    localparam logic [3:0] TOK_LINE         = 4'd2;
    localparam logic [3:0] TOK_POLYGON      = 4'd3;
    localparam logic [3:0] TOK_BITMAP       = 4'd4;
    localparam logic [3:0] TOK_DRAW_PIXEL   = 4'd5;
    localparam logic [3:0] TOK_COPY_PIXEL   = 4'd6;
    localparam logic [3:0] TOK_LINE_RESET   = 4'd7;
    localparam logic [3:0] TOK_UNKNOWN      = 4'd8;

    localparam logic [7:0]  EXP_TOKEN = 8'd137;
    localparam logic [7:0]  EXP_BIAS  = 8'd127;
    localparam logic [7:0]  EXP_HALF  = 8'd126;
    localparam logic [10:0] TOK_BASE  = 11'h700;

    // float to token index, unknown for anything outside 0x700..0x707
    function automatic logic [3:0] decode_token(input logic [WORD_W-1:0] w);
        logic [10:0] ip;
        ip = {1'b1, w[22:13]};
        if (w[31] || w[30:23] != EXP_TOKEN || ip[10:3] != TOK_BASE[10:3])
            return TOK_UNKNOWN;
        return {1'b0, ip[2:0]};
    endfunction

    // float to vertex count, truncated, clamped to 0..COUNT_MAX
    function automatic logic [COUNT_W-1:0] decode_count(input logic [WORD_W-1:0] w);
        logic [7:0]  e;
        logic [23:0] sig;
        logic [4:0]  shamt;
        e     = w[30:23] - EXP_BIAS;
        sig   = {1'b1, w[22:0]};
        shamt = 5'd23 - e[4:0];
        if (w[31] || w[30:23] < EXP_BIAS)
            return '0;
        if (e >= 8'd17)
            return COUNT_MAX;
        return COUNT_W'(sig >> shamt);
    endfunction

    // 200 * fraction >> 7, valid only when 0.5 <= z < 1
    function automatic logic [DIST_W-1:0] depth_of(input logic [WORD_W-1:0] w);
        logic [30:0] m;
        logic [30:0] prod;
        m    = {8'd0, w[22:0]};
        prod = (m << 7) + (m << 6) + (m << 3);
        return prod[30:7];
    endfunction

    function automatic logic depth_ok(input logic [WORD_W-1:0] w);
        logic [DIST_W-1:0] d;
        d = depth_of(w);
        return !w[31] && (w[30:23] == EXP_HALF) && (d >= DIST_MIN) && (d < DIST_LIMIT);
    endfunction

endpackage

### hdl/feedback_depth_center_parser.sv
// feedback depth-center parser: walks a 3D feedback stream, one word per beat
// depends on fdcp_pkg
//
//  channel   dir  payload                                   beat
//  s_axis    in   tdata = word, tlast = last, tuser = ovf   one feedback word
//  m_axis    out  tdata = depth_center, found, desynced     one per stream
//
// one word per cycle sustained, except while a last word waits on a stalled result
// the input register feeds the token/count/vertex decode, which updates the
// parse state and the result register in the same cycle
// rst_n clears parse state and both valid flags asynchronously
// a stalled result holds only words marked last; other words keep flowing
module feedback_depth_center_parser
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [fdcp_pkg::WORD_W-1:0]   s_axis_tdata,   // [31:0] word
    input  logic                          s_axis_tlast,   // last word of stream
    input  logic                          s_axis_tuser,   // [0] overflow
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [fdcp_pkg::M_DATA_W-1:0] m_axis_tdata    // [23:0] depth_center,
                                                          // [24] found, [25] desynced,
                                                          // [31:26] zero
);

    typedef enum logic [1:0]
    {
        MODE_TOKEN,
        MODE_COUNT,
        MODE_SKIP,
        MODE_VERTEX
    } mode_t;

    // input register
    logic                        in_valid_reg, in_valid_next;
    logic [fdcp_pkg::WORD_W-1:0] in_word_reg;
    logic                        in_last_reg;
    logic                        in_ovf_reg;

    // parse state
    mode_t                        mode_reg, mode_next;
    logic [fdcp_pkg::COUNT_W-1:0] vleft_reg, vleft_next;
    logic [1:0]                   wiv_reg, wiv_next;
    logic                         have_reg, have_next;
    logic [fdcp_pkg::DIST_W-1:0]  min_reg, min_next;
    logic [fdcp_pkg::DIST_W-1:0]  max_reg, max_next;
    logic                         halted_reg, halted_next;

    // result register
    logic                        out_valid_reg, out_valid_next;
    logic [fdcp_pkg::DIST_W-1:0] center_reg, center_next;
    logic                        found_reg, found_next;
    logic                        desync_reg, desync_next;

    logic advance;
    logic accept;

    // a non-last word never needs the output side; a last word needs a free result slot
    assign advance       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        mode_t                        p_mode;
        logic [fdcp_pkg::COUNT_W-1:0] p_vleft;
        logic [fdcp_pkg::COUNT_W-1:0] cnt;
        logic [1:0]                   p_wiv;
        logic                         p_have;
        logic [fdcp_pkg::DIST_W-1:0]  p_min;
        logic [fdcp_pkg::DIST_W-1:0]  p_max;
        logic                         p_halted;
        logic [fdcp_pkg::DIST_W-1:0]  d;
        logic [fdcp_pkg::DIST_W:0]    sum;
        logic [3:0]                   tok;

        p_mode   = mode_reg;
        p_vleft  = vleft_reg;
        p_wiv    = wiv_reg;
        p_have   = have_reg;
        p_min    = min_reg;
        p_max    = max_reg;
        p_halted = halted_reg;
        cnt      = fdcp_pkg::decode_count(in_word_reg);
        d        = fdcp_pkg::depth_of(in_word_reg);
        tok      = fdcp_pkg::decode_token(in_word_reg);

        if (!halted_reg)
        begin
            case (mode_reg)
                MODE_TOKEN:
                begin
                    case (tok)
                        fdcp_pkg::TOK_PASS_THROUGH: p_mode = MODE_SKIP;
                        fdcp_pkg::TOK_POINT,
                        fdcp_pkg::TOK_BITMAP,
                        fdcp_pkg::TOK_DRAW_PIXEL,
                        fdcp_pkg::TOK_COPY_PIXEL:
                        begin
                            p_vleft = fdcp_pkg::COUNT_W'(1);
                            p_wiv   = '0;
                            p_mode  = MODE_VERTEX;
                        end
                        fdcp_pkg::TOK_LINE,
                        fdcp_pkg::TOK_LINE_RESET:
                        begin
                            p_vleft = fdcp_pkg::COUNT_W'(2);
                            p_wiv   = '0;
                            p_mode  = MODE_VERTEX;
                        end
                        fdcp_pkg::TOK_POLYGON: p_mode = MODE_COUNT;
                        default: p_halted = 1'b1;
                    endcase
                end
                MODE_COUNT:
                begin
                    p_vleft = cnt;
                    p_wiv   = '0;
                    p_mode  = (cnt != '0) ? MODE_VERTEX : MODE_TOKEN;
                end
                MODE_SKIP:
                begin
                    p_mode = MODE_TOKEN;
                end
                default:
                begin
                    // third word of a vertex carries window z
                    if (wiv_reg >= 2'd2)
                    begin
                        if (fdcp_pkg::depth_ok(in_word_reg))
                        begin
                            if (!have_reg || d < min_reg)
                                p_min = d;
                            if (!have_reg || d > max_reg)
                                p_max = d;
                            p_have = 1'b1;
                        end
                        p_wiv   = '0;
                        p_vleft = vleft_reg - fdcp_pkg::COUNT_W'(1);
                        if (p_vleft == '0)
                            p_mode = MODE_TOKEN;
                    end
                    else
                    begin
                        p_wiv = wiv_reg + 2'd1;
                    end
                end
            endcase
        end

        sum = {1'b0, p_min} + {1'b0, p_max};

        mode_next      = mode_reg;
        vleft_next     = vleft_reg;
        wiv_next       = wiv_reg;
        have_next      = have_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        halted_next    = halted_reg;
        center_next    = center_reg;
        found_next     = found_reg;
        desync_next    = desync_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        if (advance)
        begin
            if (in_last_reg)
            begin
                // close the stream and start the next one from a clean state
                out_valid_next = 1'b1;
                center_next    = (p_have && !in_ovf_reg) ? sum[fdcp_pkg::DIST_W:1] : '0;
                found_next     = p_have && !in_ovf_reg;
                desync_next    = p_halted && !in_ovf_reg;
                mode_next      = MODE_TOKEN;
                vleft_next     = '0;
                wiv_next       = '0;
                have_next      = 1'b0;
                min_next       = '0;
                max_next       = '0;
                halted_next    = 1'b0;
            end
            else
            begin
                mode_next   = p_mode;
                vleft_next  = p_vleft;
                wiv_next    = p_wiv;
                have_next   = p_have;
                min_next    = p_min;
                max_next    = p_max;
                halted_next = p_halted;
            end
        end

        in_valid_next = accept || (in_valid_reg && !advance);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_TOKEN;
            vleft_reg     <= '0;
            wiv_reg       <= '0;
            have_reg      <= 1'b0;
            min_reg       <= '0;
            max_reg       <= '0;
            halted_reg    <= 1'b0;
            center_reg    <= '0;
            found_reg     <= 1'b0;
            desync_reg    <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            mode_reg      <= mode_next;
            vleft_reg     <= vleft_next;
            wiv_reg       <= wiv_next;
            have_reg      <= have_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            halted_reg    <= halted_next;
            center_reg    <= center_next;
            found_reg     <= found_next;
            desync_reg    <= desync_next;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_word_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
            in_ovf_reg  <= s_axis_tuser;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, desync_reg, found_reg, center_reg};

endmodule

### hdl/fdcp_checker.sv
// port-level checker for the feedback depth-center parser, with its bind
// depends on fdcp_pkg and feedback_depth_center_parser_macros.svh
`include "feedback_depth_center_parser_macros.svh"

module fdcp_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [fdcp_pkg::M_DATA_W-1:0] m_axis_tdata
);

    // a stalled result beat keeps its payload
    `FDCP_ASSERT_NEXT(a_out_hold, clk, rst_n,
        m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata),
        "result beat changed while stalled")

    // no counted distance means a zero center
    `FDCP_ASSERT_NOW(a_none_zero, clk, rst_n,
        m_axis_tvalid && !m_axis_tdata[24],
        m_axis_tdata[23:0] == '0,
        "center nonzero without found")

    // midpoint of counted distances stays in the counted range
    `FDCP_ASSERT_NOW(a_center_range, clk, rst_n,
        m_axis_tvalid && m_axis_tdata[24],
        (m_axis_tdata[23:0] >= fdcp_pkg::DIST_MIN) && (m_axis_tdata[23:0] < fdcp_pkg::DIST_LIMIT),
        "center outside counted range")

    // padding bits stay zero
    `FDCP_ASSERT_NOW(a_pad_zero, clk, rst_n,
        m_axis_tvalid,
        m_axis_tdata[31:26] == '0,
        "padding bits set in result beat")

endmodule

bind feedback_depth_center_parser fdcp_checker u_fdcp_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### tb/sv/feedback_depth_center_parser_test.sv
// self-checking bench for feedback_depth_center_parser: feeds feedback words,
// predicts each stream's depth center and checks every result beat
// depends on fdcp_pkg and the feedback_depth_center_parser rtl
module feedback_depth_center_parser_test;

    timeunit 1ns;
    timeprecision 1ps;

    // where the walker sits inside a stream
    typedef enum logic [1:0] {
        WALK_TOKEN  = 2'd0,
        WALK_COUNT  = 2'd1,
        WALK_SKIP   = 2'd2,
        WALK_VERTEX = 2'd3
    } walk_t;

    // one stream summary, same layout as m_axis_tdata[25:0]
    typedef struct packed {
        logic        desynced;
        logic        found;
        logic [23:0] center;
    } summary_t;

    localparam int unsigned HOLD_CYCLES = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // [31:0] word
    logic        s_axis_tlast = 1'b0;   // last word of stream
    logic        s_axis_tuser = 1'b0;   // [0] overflow
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [23:0] depth_center, [24] found, [25] desynced

    feedback_depth_center_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // walker state mirrored from the block
    walk_t       walk = WALK_TOKEN;
    int unsigned verts_left = 0;
    int unsigned vert_word = 0;
    bit          seen_any = 1'b0;
    int unsigned near_dist = 0;
    int unsigned far_dist = 0;
    bit          lost = 1'b0;

    summary_t    centers_due[$];

    // run bookkeeping
    int unsigned mismatches = 0;
    int unsigned words_sent = 0;
    int unsigned streams_done = 0;
    int unsigned results_seen = 0;
    int unsigned with_depth = 0;
    int unsigned with_desync = 0;
    int unsigned zeroed = 0;

    // idling controls
    bit          calm = 1'b0;           // no idling on either side
    bit          steady = 1'b0;         // sender keeps a stretch without gaps
    int unsigned hold_asks = 0;         // bumped to ask the receiver for a long hold

    task automatic report(input string msg);
        mismatches++;
        // quiet after forty lines, still counting
        if (mismatches <= 40)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // depth-center predictor
    // ------------------------------------------------------------------

    // float word to token index, unknown for anything but 1792..1799 after truncation
    function automatic logic [3:0] token_of(input logic [31:0] w);
        logic [10:0] whole;
        if (w[31] || w[30:23] != 8'd137)
            return fdcp_pkg::TOK_UNKNOWN;
        whole = {1'b1, w[22:13]};
        if (whole < 11'd1792 || whole > 11'd1799)
            return fdcp_pkg::TOK_UNKNOWN;
        return 4'(whole - 11'd1792);
    endfunction

    // float word to polygon vertex count, truncated and saturated
    function automatic int unsigned count_of(input logic [31:0] w);
        int unsigned e;
        if (w[31] || w[30:23] < 8'd127)
            return 0;
        e = int'(w[30:23]) - 127;
        if (e >= 17)
            return int'(fdcp_pkg::COUNT_MAX);
        return {8'd0, 1'b1, w[22:0]} >> (23 - e);
    endfunction

    // window z to eye distance; only 0.5 <= z < 1 and 7 <= d < 13107200 count
    function automatic void take_z(input logic [31:0] w);
        int unsigned d;
        if (w[31] || w[30:23] != 8'd126)
            return;
        d = (32'd200 * {9'd0, w[22:0]}) >> 7;
        if (d < fdcp_pkg::DIST_MIN || d >= fdcp_pkg::DIST_LIMIT)
            return;
        if (!seen_any || d < near_dist)
            near_dist = d;
        if (!seen_any || d > far_dist)
            far_dist = d;
        seen_any = 1'b1;
    endfunction

    function automatic void open_vertices(input int unsigned n);
        verts_left = n;
        vert_word = 0;
        walk = (n != 0) ? WALK_VERTEX : WALK_TOKEN;
    endfunction

    function automatic void clear_walk();
        walk = WALK_TOKEN;
        verts_left = 0;
        vert_word = 0;
        seen_any = 1'b0;
        near_dist = 0;
        far_dist = 0;
        lost = 1'b0;
    endfunction

    // advance the walker by one accepted word; the last word queues a summary
    function automatic void track_word(input logic [31:0] w, input bit lst, input bit ovf);
        summary_t s;
        if (!lost)
        begin
            case (walk)
                WALK_TOKEN:
                begin
                    case (token_of(w))
                        fdcp_pkg::TOK_PASS_THROUGH: walk = WALK_SKIP;
                        fdcp_pkg::TOK_POINT,
                        fdcp_pkg::TOK_BITMAP,
                        fdcp_pkg::TOK_DRAW_PIXEL,
                        fdcp_pkg::TOK_COPY_PIXEL:
                            open_vertices(1);
                        fdcp_pkg::TOK_LINE,
                        fdcp_pkg::TOK_LINE_RESET:
                            open_vertices(2);
                        fdcp_pkg::TOK_POLYGON: walk = WALK_COUNT;
                        default: lost = 1'b1;
                    endcase
                end
                WALK_COUNT: open_vertices(count_of(w));
                WALK_SKIP: walk = WALK_TOKEN;
                default:
                begin
                    if (vert_word >= 2)
                    begin
                        take_z(w);
                        vert_word = 0;
                        verts_left--;
                        if (verts_left == 0)
                            walk = WALK_TOKEN;
                    end
                    else
                    begin
                        vert_word++;
                    end
                end
            endcase
        end
        if (!lst)
            return;
        // an open token, count, skip or vertex is simply dropped here
        if (ovf)
        begin
            s = '0;
            zeroed++;
        end
        else
        begin
            s.desynced = lost;
            s.found = seen_any;
            s.center = seen_any ? 24'((near_dist + far_dist) >> 1) : 24'd0;
            if (seen_any)
                with_depth++;
            if (lost)
                with_desync++;
        end
        centers_due.push_back(s);
        streams_done++;
        clear_walk();
    endfunction

    // ------------------------------------------------------------------
    // word builders
    // ------------------------------------------------------------------

    // token value 0x700+t, random fraction bits below the integer part
    function automatic logic [31:0] token_word(input logic [3:0] t);
        return {1'b0, 8'd137, 10'(10'h300 + t), 13'($urandom)};
    endfunction

    // window z inside [0.5, 1)
    function automatic logic [31:0] z_word(input logic [22:0] frac);
        return {1'b0, 8'd126, frac};
    endfunction

    // count n >= 1 as a float, with a random fraction that truncation drops
    function automatic logic [31:0] count_word(input int unsigned n);
        int unsigned top;
        logic [23:0] sig;
        top = 0;
        for (int b = 0; b < 17; b++)
            if (n[b])
                top = b;
        sig = 24'(n << (23 - top));
        sig = sig | (24'($urandom) & ((24'd1 << (23 - top)) - 24'd1));
        return {1'b0, 8'(127 + top), sig[22:0]};
    endfunction

    // ------------------------------------------------------------------
    // stimulus side
    // ------------------------------------------------------------------

    // offer one beat and wait for it to be taken; starts and ends just after an edge
    task automatic send_word(input logic [31:0] w, input bit lst, input bit ovf);
        if (!calm && !steady && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= w;
        s_axis_tlast <= lst;
        s_axis_tuser <= ovf;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        track_word(w, lst, ovf);
        words_sent++;
    endtask

    // one vertex: x and y arbitrary, z mostly in the counted range
    function automatic void push_vertex(ref logic [31:0] words[$]);
        int unsigned pick;
        words.push_back($urandom);
        words.push_back($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 75)
            words.push_back(z_word(23'($urandom)));
        else if (pick < 85)
            words.push_back($urandom);
        else if (pick < 92)
            words.push_back(z_word(23'($urandom_range(0, 8))));
        else
            words.push_back(z_word(23'h7FFFFF - 23'($urandom_range(0, 8))));
    endfunction

    // build and send one stream of up to prims primitives; messy streams add
    // stray tokens, odd counts and early ends
    task automatic random_stream(input int unsigned prims, input bit messy);
        logic [31:0] words[$];
        logic [3:0]  tok;
        int unsigned n;
        int unsigned pick;
        bit          cut;
        bit          ovf;
        cut = 1'b0;
        for (int p = 0; p < prims && !cut; p++)
        begin
            if (messy && $urandom_range(0, 99) < 5)
            begin
                words.push_back($urandom);
                continue;
            end
            tok = 4'($urandom_range(0, 7));
            words.push_back(token_word(tok));
            case (tok)
                fdcp_pkg::TOK_PASS_THROUGH: words.push_back($urandom);
                fdcp_pkg::TOK_LINE,
                fdcp_pkg::TOK_LINE_RESET:
                begin
                    push_vertex(words);
                    push_vertex(words);
                end
                fdcp_pkg::TOK_POLYGON:
                begin
                    pick = $urandom_range(0, 99);
                    if (!messy || pick < 85)
                    begin
                        n = $urandom_range(1, 5);
                        words.push_back(count_word(n));
                        repeat (n) push_vertex(words);
                    end
                    else if (pick < 90)
                    begin
                        // below one, zero or negative: back to token mode
                        case ($urandom_range(0, 2))
                            0: words.push_back(32'h0);
                            1: words.push_back({1'b0, 8'($urandom_range(0, 126)), 23'($urandom)});
                            default: words.push_back({1'b1, 31'($urandom)});
                        endcase
                    end
                    else
                    begin
                        // huge, infinite or nan count; the stream ends inside it
                        words.push_back({1'b0, 8'($urandom_range(144, 255)), 23'($urandom)});
                        repeat ($urandom_range(0, 3)) push_vertex(words);
                        cut = 1'b1;
                    end
                end
                default: push_vertex(words);
            endcase
        end
        if (messy && words.size() > 1 && $urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, words.size() - 1)) void'(words.pop_back());
        if (words.size() == 0)
            words.push_back($urandom_range(0, 1) ? token_word(4'($urandom_range(0, 7)))
                                                   : 32'($urandom));
        ovf = ($urandom_range(0, 9) == 0);
        steady = ($urandom_range(0, 3) == 0);
        foreach (words[i])
        begin
            if (i == words.size() - 1)
                send_word(words[i], 1'b1, ovf);
            else
                send_word(words[i], 1'b0, 1'($urandom_range(0, 1)));   // tuser ignored here
        end
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls, long holds on request, checks every beat
    // ------------------------------------------------------------------
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;
    int unsigned quiet_left = 0;

    always @(posedge clk)
    begin : result_side
        summary_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (centers_due.size() == 0)
            begin
                report($sformatf("result beat with no stream pending, tdata %h", m_axis_tdata));
            end
            else
            begin
                want = centers_due.pop_front();
                if (m_axis_tdata[23:0] !== want.center)
                    report($sformatf("depth_center %0d, expected %0d",
                                     m_axis_tdata[23:0], want.center));
                if (m_axis_tdata[24] !== want.found)
                    report($sformatf("found %b, expected %b", m_axis_tdata[24], want.found));
                if (m_axis_tdata[25] !== want.desynced)
                    report($sformatf("desynced %b, expected %b",
                                     m_axis_tdata[25], want.desynced));
            end
            results_seen++;
        end
        // a new hold request overrides the usual stall pattern
        if (hold_seen != hold_asks)
        begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (calm || quiet_left != 0)
        begin
            if (quiet_left != 0)
                quiet_left--;
            m_axis_tready <= 1'b1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            // burst of low ready, then a stretch without stalls
            stall_left = $urandom_range(1, 7) - 1;
            quiet_left = $urandom_range(0, 60);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // hand-built streams: every token, the distance edges, odd counts,
    // unknown token, overflow and streams that end mid-primitive
    task automatic test_directed();
        // point with z at the lowest counted distance (7)
        send_word(token_word(fdcp_pkg::TOK_POINT), 1'b0, 1'b0);
        send_word(32'h3F80_0000, 1'b0, 1'b1);
        send_word(32'h0000_0000, 1'b0, 1'b0);
        send_word(z_word(23'd5), 1'b0, 1'b0);
        // line reset: z just below one counts, z one step below 7 does not
        send_word(token_word(fdcp_pkg::TOK_LINE_RESET), 1'b0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_word(32'h8000_0000, 1'b0, 1'b0);
        send_word(z_word(23'h7FFFFF), 1'b0, 1'b0);
        send_word($urandom, 1'b0, 1'b0);
        send_word($urandom, 1'b0, 1'b0);
        send_word(z_word(23'd4), 1'b0, 1'b0);
        // pass-through skips an all-ones word; stream ends on a bare bitmap token
        send_word(token_word(fdcp_pkg::TOK_PASS_THROUGH), 1'b0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_word(token_word(fdcp_pkg::TOK_BITMAP), 1'b1, 1'b0);
        // polygon with an infinite count, cut short, overflow flagged
        send_word(token_word(fdcp_pkg::TOK_POLYGON), 1'b0, 1'b0);
        send_word(32'h7F80_0000, 1'b0, 1'b0);
        send_word($urandom, 1'b0, 1'b0);
        send_word($urandom, 1'b1, 1'b1);
        // draw pixel with z exactly one, then an unknown token halts the walk
        send_word(token_word(fdcp_pkg::TOK_DRAW_PIXEL), 1'b0, 1'b0);
        send_word(32'h7FC0_0000, 1'b0, 1'b0);
        send_word(32'h3F00_0000, 1'b0, 1'b0);
        send_word(32'h3F80_0000, 1'b0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_word(token_word(fdcp_pkg::TOK_COPY_PIXEL), 1'b1, 1'b0);
        // negative polygon count gives zero vertices; ends on a line token
        send_word(token_word(fdcp_pkg::TOK_POLYGON), 1'b0, 1'b0);
        send_word(32'hC040_0000, 1'b0, 1'b0);
        send_word(token_word(fdcp_pkg::TOK_LINE), 1'b1, 1'b0);
    endtask

    // mostly well-formed streams with random content, some noise and broken ones
    task automatic test_random_streams(input int unsigned word_goal);
        int unsigned stop_at;
        stop_at = words_sent + word_goal;
        while (words_sent < stop_at)
            random_stream($urandom_range(0, 6), $urandom_range(0, 3) == 0);
    endtask

    // receiver holds off for a long stretch while short streams keep coming,
    // so the result stage fills and the input stalls
    task automatic test_result_backpressure();
        hold_asks <= hold_asks + 1;
        repeat (30) random_stream(1, 1'b0);
    endtask

    // back-to-back beats with no idling on either side
    task automatic test_full_rate(input int unsigned word_goal);
        int unsigned stop_at;
        calm <= 1'b1;
        steady = 1'b1;
        stop_at = words_sent + word_goal;
        while (words_sent < stop_at)
            random_stream($urandom_range(1, 5), $urandom_range(0, 4) == 0);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_streams(1300);
        test_result_backpressure();
        test_random_streams(100);
        test_full_rate(200);

        s_axis_tvalid <= 1'b0;
        s_axis_tlast <= 1'b0;
        while (centers_due.size() != 0)
            @(posedge clk);
        // leave room for any stray beat
        repeat (10) @(posedge clk);

        $display("covered %0d streams in %0d words: %0d with depths, %0d desynced,",
                 streams_done, words_sent, with_depth, with_desync);
        $display("%0d overflowed; checked %0d result beats, %0d mismatches",
                 zeroed, results_seen, mismatches);
        if (mismatches == 0)
            $display("feedback_depth_center_parser regression: pass");
        else
            $display("feedback_depth_center_parser regression: fail");
        $finish;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #3_000_000;
        $display("timeout with %0d results still pending", centers_due.size());
        $display("feedback_depth_center_parser regression: fail");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/fdcp_pkg.sv
hdl/feedback_depth_center_parser.sv
hdl/fdcp_checker.sv
tb/sv/feedback_depth_center_parser_test.sv
